// File: rtl/core/camera_blob_steering_decider_macros.svh
// ----------------------------------------------------------------------------
// camera blob steering decider assertion macros
// Shared concurrent assertion wrappers, sampled on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef CAMERA_BLOB_STEERING_DECIDER_MACROS_SVH
`define CAMERA_BLOB_STEERING_DECIDER_MACROS_SVH

`ifndef ASSERT_OFF

// same-cycle implication
`define CBSD_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("implication check failed");

// next-cycle implication
`define CBSD_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`else

`define CBSD_ASSERT_IMP(lbl, ante, cons)
`define CBSD_ASSERT_NXT(lbl, ante, cons)

`endif

`endif

// File: rtl/core/cbsd_pkg.sv
// ----------------------------------------------------------------------------
// cbsd_pkg
// Types, codes and constants shared by the steering decider modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package cbsd_pkg;

	// frame kinds
	localparam logic [1:0] KIND_VERSION    = 2'd0;
	localparam logic [1:0] KIND_RESOLUTION = 2'd1;
	localparam logic [1:0] KIND_BRIGHTNESS = 2'd2;
	localparam logic [1:0] KIND_BLOCKS     = 2'd3;

	// configuration register indexes
	localparam logic [1:0] CFG_CENTER_TOL  = 2'd0;
	localparam logic [1:0] CFG_NEAR_MARGIN = 2'd1;

	// configuration reset values
	localparam logic [7:0]  TOL_RESET    = 8'd10;
	localparam logic [15:0] MARGIN_RESET = 16'd500;

	// frame byte positions
	localparam logic [4:0] POS_CHK_LO     = 5'd4;
	localparam logic [4:0] POS_CHK_HI     = 5'd5;
	localparam logic [4:0] POS_PAYLOAD    = 5'd6;

	// reciprocal constants: floor(p/9) = (p*M9)>>35, floor(p/100) = (p*M100)>>38
	localparam logic [31:0] RECIP_9     = 32'd3817748708;
	localparam int          RECIP_9_SH  = 35;
	localparam logic [31:0] RECIP_100   = 32'd2748779070;
	localparam int          RECIP_100_SH = 38;

	typedef enum logic [3:0] {
		DIR_NONE    = 4'd0,
		DIR_STOP    = 4'd1,
		DIR_REVERSE = 4'd2,
		DIR_FORWARD = 4'd3,
		DIR_RIGHT   = 4'd4,
		DIR_LEFT    = 4'd5,
		DIR_SE      = 4'd6,
		DIR_SW      = 4'd7,
		DIR_NE      = 4'd8,
		DIR_NW      = 4'd9
	} dir_t;

	// captured frame and block geometry
	typedef struct packed {
		logic [15:0] frame_w;
		logic [15:0] frame_h;
		logic [15:0] center_x;
		logic [15:0] center_y;
		logic [15:0] block_w;
		logic [15:0] block_h;
		logic [7:0]  age;
	} cbsd_geom_t;

	// end-of-frame event from the byte capture
	typedef struct packed {
		logic       done;
		logic [1:0] kind;
		logic       ok;
		logic       flags_full;
	} cbsd_event_t;

	// derived area figures
	typedef struct packed {
		logic [31:0] area;
		logic [28:0] max_area;
		logic [25:0] speed;
	} cbsd_area_t;

	// frame length per kind
	function automatic logic [4:0] frame_len(input logic [1:0] kind);
		logic [4:0] len;
		unique case (kind)
			KIND_VERSION:    len = 5'd22;
			KIND_RESOLUTION: len = 5'd10;
			KIND_BRIGHTNESS: len = 5'd10;
			KIND_BLOCKS:     len = 5'd20;
			default:         len = 5'd20;
		endcase
		return len;
	endfunction

endpackage

// File: rtl/core/cbsd_capture.sv
// ----------------------------------------------------------------------------
// cbsd_capture
// Byte position tracking, checksum accumulation, field capture and pass flags.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cbsd_capture import cbsd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        acc,
	input  logic [1:0]  req_type,
	input  logic        frame_start,
	input  logic [7:0]  rx_byte,
	output cbsd_geom_t  geom,
	output cbsd_event_t ev
);

	logic [4:0]  pos_q;
	logic [15:0] sum_q;
	logic [15:0] chk_q;
	logic [2:0]  flags_q;
	cbsd_geom_t  geom_q;

	logic [4:0]  len;
	logic [4:0]  pos_cur;
	logic [4:0]  pos_inc;
	logic [15:0] sum_cur;
	logic [15:0] chk_cur;
	logic [15:0] sum_nx;
	logic [15:0] chk_nx;
	logic        live;
	logic        ok;

	// frame start restarts position and checksum state
	always_comb begin
		len     = frame_len(req_type);
		pos_cur = frame_start ? 5'd0 : pos_q;
		sum_cur = frame_start ? 16'd0 : sum_q;
		chk_cur = frame_start ? 16'd0 : chk_q;
		live    = pos_cur < len;
		pos_inc = pos_cur + 5'd1;
	end

	// checksum and payload sum including the current byte
	always_comb begin
		sum_nx = sum_cur;
		chk_nx = chk_cur;
		if (pos_cur == POS_CHK_LO) begin
			chk_nx = {chk_cur[15:8], rx_byte};
		end else if (pos_cur == POS_CHK_HI) begin
			chk_nx = {rx_byte, chk_cur[7:0]};
		end else if (pos_cur >= POS_PAYLOAD) begin
			sum_nx = sum_cur + {8'd0, rx_byte};
		end
		ok = (chk_nx == sum_nx);
	end

	assign ev.done       = acc && live && (pos_inc == len);
	assign ev.kind       = req_type;
	assign ev.ok         = ok;
	assign ev.flags_full = (flags_q == 3'b111);
	assign geom          = geom_q;

	// position, sums and pass flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			sum_q   <= '0;
			chk_q   <= '0;
			flags_q <= '0;
		end else if (acc && live) begin
			pos_q <= pos_inc;
			sum_q <= sum_nx;
			chk_q <= chk_nx;
			if (ev.done && req_type != KIND_BLOCKS) begin
				flags_q[req_type] <= ok;
			end
		end
	end

	// field capture by kind and position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			geom_q <= '0;
		end else if (acc && live) begin
			if (req_type == KIND_RESOLUTION) begin
				case (pos_cur)
					5'd6:    geom_q.frame_w[7:0]  <= rx_byte;
					5'd7:    geom_q.frame_w[15:8] <= rx_byte;
					5'd8:    geom_q.frame_h[7:0]  <= rx_byte;
					5'd9:    geom_q.frame_h[15:8] <= rx_byte;
					default: ;
				endcase
			end else if (req_type == KIND_BLOCKS) begin
				case (pos_cur)
					5'd8:    geom_q.center_x[7:0]  <= rx_byte;
					5'd9:    geom_q.center_x[15:8] <= rx_byte;
					5'd10:   geom_q.center_y[7:0]  <= rx_byte;
					5'd11:   geom_q.center_y[15:8] <= rx_byte;
					5'd12:   geom_q.block_w[7:0]   <= rx_byte;
					5'd13:   geom_q.block_w[15:8]  <= rx_byte;
					5'd14:   geom_q.block_h[7:0]   <= rx_byte;
					5'd15:   geom_q.block_h[15:8]  <= rx_byte;
					5'd18:   geom_q.age            <= rx_byte;
					default: ;
				endcase
			end
		end
	end

endmodule

// File: rtl/core/cbsd_area.sv
// ----------------------------------------------------------------------------
// cbsd_area
// Registered products: block area, maximum area (frame area / 9), speed
// (area / 100), the divisions done by reciprocal multiplication.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cbsd_area import cbsd_pkg::*; (
	input  logic       clk,
	input  cbsd_geom_t geom,
	output cbsd_area_t area
);

	logic [31:0] area_q;
	logic [31:0] frame_area_q;
	logic [63:0] speed_prod_q;
	logic [63:0] max_prod_q;
	logic [25:0] speed_q;
	logic [28:0] max_area_q;

	// products follow the captured fields continuously
	always_ff @(posedge clk) begin
		area_q       <= {16'd0, geom.block_w} * {16'd0, geom.block_h};
		frame_area_q <= {16'd0, geom.frame_w} * {16'd0, geom.frame_h};
		speed_prod_q <= {32'd0, area_q} * {32'd0, RECIP_100};
		max_prod_q   <= {32'd0, frame_area_q} * {32'd0, RECIP_9};
		speed_q      <= speed_prod_q[63:RECIP_100_SH];
		max_area_q   <= max_prod_q[63:RECIP_9_SH];
	end

	assign area.area     = area_q;
	assign area.max_area = max_area_q;
	assign area.speed    = speed_q;

endmodule

// File: rtl/core/cbsd_steer.sv
// ----------------------------------------------------------------------------
// cbsd_steer
// Window and area rules that pick the steering direction and speed.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cbsd_steer import cbsd_pkg::*; (
	input  cbsd_geom_t  geom,
	input  cbsd_area_t  area,
	input  logic [7:0]  center_tol,
	input  logic [15:0] near_margin,
	output dir_t        dir,
	output logic [25:0] speed
);

	logic signed [17:0] min_w;
	logic signed [17:0] max_w;
	logic signed [17:0] min_h;
	logic signed [17:0] max_h;
	logic signed [17:0] cx;
	logic signed [17:0] cy;
	logic [31:0]        max_area;
	logic               x_in;
	logic               y_in;
	logic               x_above;
	logic               x_below;
	logic               too_big;
	logic               near;

	// centre window, bounds may go negative
	always_comb begin
		min_w   = $signed({3'd0, geom.frame_w[15:1]}) - $signed({10'd0, center_tol});
		max_w   = $signed({3'd0, geom.frame_w[15:1]}) + $signed({10'd0, center_tol});
		min_h   = $signed({3'd0, geom.frame_h[15:1]}) - $signed({10'd0, center_tol});
		max_h   = $signed({3'd0, geom.frame_h[15:1]}) + $signed({10'd0, center_tol});
		cx      = $signed({2'd0, geom.center_x});
		cy      = $signed({2'd0, geom.center_y});
		x_above = cx > max_w;
		x_below = cx < min_w;
		x_in    = !x_above && !x_below;
		y_in    = (cy >= min_h) && (cy <= max_h);
	end

	// area rules
	always_comb begin
		max_area = {3'd0, area.max_area};
		too_big  = area.area > max_area;
		near     = (max_area - area.area) <= {16'd0, near_margin};
	end

	// direction priority
	always_comb begin
		dir   = DIR_NONE;
		speed = area.speed;
		if (geom.age == 8'd0) begin
			dir   = DIR_STOP;
			speed = '0;
		end else if (too_big) begin
			dir = DIR_REVERSE;
		end else if (near) begin
			if (x_in) begin
				dir   = y_in ? DIR_STOP : DIR_NONE;
				speed = '0;
			end else if (y_in) begin
				dir = x_above ? DIR_RIGHT : DIR_LEFT;
			end else begin
				dir = x_above ? DIR_SE : DIR_SW;
			end
		end else if (x_above) begin
			dir = DIR_NE;
		end else if (x_below) begin
			dir = DIR_NW;
		end else begin
			dir = DIR_FORWARD;
		end
	end

endmodule

// File: rtl/core/camera_blob_steering_decider.sv
// ----------------------------------------------------------------------------
// camera_blob_steering_decider
// The result register loads on the clock edge that accepts the last byte of a frame.
// Throughput: one byte per cycle; a result held by res_stall stalls input.
// Area products register as products, reciprocal products and quotients behind
// the captured fields; block size bytes always end four bytes before a frame end.
// Reset clears position, sums, captured fields, pass flags and the result valid flag.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "camera_blob_steering_decider_macros.svh"

module camera_blob_steering_decider import cbsd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	// byte channel
	input  logic        byte_valid,
	output logic        byte_stall,
	input  logic [1:0]  req_type,
	input  logic        frame_start,
	input  logic [7:0]  rx_byte,
	// result channel
	output logic        res_valid,
	input  logic        res_stall,
	output logic [1:0]  frame_kind,
	output logic        frame_ok,
	output logic        decision_valid,
	output logic [3:0]  direction,
	output logic [25:0] speed,
	// configuration write channel
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	logic [7:0]  center_tol_q;
	logic [15:0] near_margin_q;

	logic        res_valid_q;
	logic [1:0]  kind_q;
	logic        ok_q;
	logic        dv_q;
	logic [3:0]  dir_q;
	logic [25:0] speed_q;

	logic        acc;
	logic        dv;
	cbsd_geom_t  geom;
	cbsd_event_t ev;
	cbsd_area_t  area;
	dir_t        steer_dir;
	logic [25:0] steer_speed;

	// configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_tol_q  <= TOL_RESET;
			near_margin_q <= MARGIN_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_CENTER_TOL:  center_tol_q  <= cfg_data[7:0];
				CFG_NEAR_MARGIN: near_margin_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// byte transaction accepted while the result register can take a result
	assign byte_stall = res_valid_q && res_stall;
	assign acc        = byte_valid && !byte_stall;

	cbsd_capture u_capture (
		.clk         (clk),
		.arst_n      (arst_n),
		.acc         (acc),
		.req_type    (req_type),
		.frame_start (frame_start),
		.rx_byte     (rx_byte),
		.geom        (geom),
		.ev          (ev)
	);

	cbsd_area u_area (
		.clk  (clk),
		.geom (geom),
		.area (area)
	);

	cbsd_steer u_steer (
		.geom        (geom),
		.area        (area),
		.center_tol  (center_tol_q),
		.near_margin (near_margin_q),
		.dir         (steer_dir),
		.speed       (steer_speed)
	);

	assign dv = (ev.kind == KIND_BLOCKS) && ev.ok && ev.flags_full;

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (ev.done) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ev.done) begin
			kind_q  <= ev.kind;
			ok_q    <= ev.ok;
			dv_q    <= dv;
			dir_q   <= dv ? steer_dir : DIR_NONE;
			speed_q <= dv ? steer_speed : 26'd0;
		end
	end

	assign res_valid      = res_valid_q;
	assign frame_kind     = kind_q;
	assign frame_ok       = ok_q;
	assign decision_valid = dv_q;
	assign direction      = dir_q;
	assign speed          = speed_q;

	// checks
	`CBSD_ASSERT_IMP(a_dv_blocks_ok, res_valid_q && dv_q, kind_q == KIND_BLOCKS && ok_q)
	`CBSD_ASSERT_IMP(a_no_dv_quiet, res_valid_q && !dv_q, dir_q == DIR_NONE && speed_q == 26'd0)
	`CBSD_ASSERT_IMP(a_stop_no_speed, res_valid_q && (dir_q == DIR_STOP || dir_q == DIR_NONE), speed_q == 26'd0)
	`CBSD_ASSERT_NXT(a_done_loads, ev.done, res_valid_q && kind_q == $past(ev.kind))

endmodule
